// File: design/fst_pkg.sv
// fst_pkg: types, command and status codes and fixed constants of the solar tracker
// no dependencies; used by fst_cfg_if, fst_cfg_regs, fst_step, the top level, the checker and the bench

package fst_pkg;

    // command codes on the func field
    localparam logic [1:0] FUNC_TRACK  = 2'd0;
    localparam logic [1:0] FUNC_SEARCH = 2'd1;
    localparam logic [1:0] FUNC_EAST   = 2'd2;

    // search status codes
    localparam logic [1:0] STAT_IDLE      = 2'd0;
    localparam logic [1:0] STAT_FOUND     = 2'd1;
    localparam logic [1:0] STAT_SEARCHING = 2'd2;
    localparam logic [1:0] STAT_GIVE_UP   = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_STEP_DEG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_SWEEPS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_HOME        = 3'd4;
    localparam int unsigned CFG_DATA_W = 10;

    // angle constants
    localparam logic [8:0] PAN_FLIP   = 9'd180;
    localparam logic [7:0] TILT_MID   = 8'd90;
    localparam logic [9:0] HALF_TURN  = 10'd180;
    localparam logic [7:0] TILT_RESET = 8'd45;
    localparam logic [7:0] SERVO_MAX  = 8'd255;

    typedef struct packed {
        logic [9:0] track_threshold;
        logic [9:0] search_tolerance;
        logic [7:0] search_step_deg;
        logic [7:0] search_sweeps;
        logic [7:0] tilt_home;
    } cfg_t;

    typedef struct packed {
        logic [1:0] func;
        logic [9:0] light_nw;
        logic [9:0] light_ne;
        logic [9:0] light_sw;
        logic [9:0] light_se;
    } sample_t;

    typedef struct packed {
        logic [7:0] pan_servo;
        logic [7:0] tilt_servo;
        logic [8:0] pan_heading;
        logic       pane_flipped;
        logic [1:0] search_status;
    } result_t;

    typedef struct packed {
        logic [8:0] heading;
        logic [7:0] tilt;
        logic       searching;
        logic [8:0] sweep_progress;
        logic [7:0] sweeps_done;
    } state_t;

endpackage

// File: design/fst_sample_if.sv
// fst_sample_if: input channel of the solar tracker, one sensor sample and command per beat
// no dependencies

interface fst_sample_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [9:0] light_nw;
    logic [9:0] light_ne;
    logic [9:0] light_sw;
    logic [9:0] light_se;

    modport source (output valid, func, light_nw, light_ne, light_sw, light_se, input ready);
    modport sink   (input valid, func, light_nw, light_ne, light_sw, light_se, output ready);
endinterface

// File: design/fst_result_if.sv
// fst_result_if: result channel of the solar tracker, servo commands and search status
// no dependencies

interface fst_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] pan_servo;
    logic [7:0] tilt_servo;
    logic [8:0] pan_heading;
    logic       pane_flipped;
    logic [1:0] search_status;

    modport source (output valid, pan_servo, tilt_servo, pan_heading, pane_flipped,
                    search_status, input ready);
    modport sink   (input valid, pan_servo, tilt_servo, pan_heading, pane_flipped,
                    search_status, output ready);
endinterface

// File: design/fst_cfg_if.sv
// fst_cfg_if: configuration write channel, register index and data per beat
// depends on fst_pkg for the index and data widths

interface fst_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fst_pkg::CFG_IDX_W-1:0]  index;
    logic [fst_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/fst_cfg_regs.sv
// fst_cfg_regs: configuration register file of the solar tracker
// depends on fst_pkg and fst_cfg_if

module fst_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    fst_cfg_if.sink          cfg,
    output fst_pkg::cfg_t    regs
);

    fst_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.track_threshold  <= 10'd50;
            cfg_reg.search_tolerance <= 10'd500;
            cfg_reg.search_step_deg  <= 8'd10;
            cfg_reg.search_sweeps    <= 8'd2;
            cfg_reg.tilt_home        <= 8'd45;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                fst_pkg::CFG_TRACK_THRESHOLD:  cfg_reg.track_threshold  <= cfg.data;
                fst_pkg::CFG_SEARCH_TOLERANCE: cfg_reg.search_tolerance <= cfg.data;
                fst_pkg::CFG_SEARCH_STEP_DEG:  cfg_reg.search_step_deg  <= cfg.data[7:0];
                fst_pkg::CFG_SEARCH_SWEEPS:    cfg_reg.search_sweeps    <= cfg.data[7:0];
                fst_pkg::CFG_TILT_HOME:        cfg_reg.tilt_home        <= cfg.data[7:0];
                default: ;
            endcase
        end
    end

endmodule

// File: design/fst_step.sv
// fst_step: one tracker step, next pan/tilt/search state and the result item
// depends on fst_pkg; purely combinational, sits between the input and result registers

module fst_step #(
    parameter int unsigned PAN_RANGE  = 360,
    parameter int unsigned TILT_RANGE = 180
) (
    input  fst_pkg::sample_t item,
    input  fst_pkg::state_t  st,
    input  fst_pkg::cfg_t    cfg,
    output fst_pkg::state_t  st_next,
    output fst_pkg::result_t res
);

    localparam logic [9:0] PAN_MOD  = 10'(PAN_RANGE + 1);
    localparam logic [9:0] PAN_MAX  = 10'(PAN_RANGE);
    localparam logic [7:0] TILT_TOP = 8'(TILT_RANGE);

    // target stays below three turns, so two conditional subtracts wrap it
    function automatic logic [8:0] pan_wrap(input logic [9:0] target);
        logic [9:0] t;
        begin
            t = target;
            if (t >= PAN_MOD)
                t = t - PAN_MOD;
            if (t >= PAN_MOD)
                t = t - PAN_MOD;
            pan_wrap = t[8:0];
        end
    endfunction

    always_comb
    begin
        logic [10:0]       sum_w, sum_e, sum_n, sum_s;
        logic signed [10:0] dh, dv;
        logic [10:0]       mag_h, mag_v;
        logic              move_h, move_v;
        logic              pan_up;
        logic              pan_move;
        logic [9:0]        pan_tgt;
        logic [8:0]        pan_nxt;
        logic [7:0]        tilt_a, tilt_b;
        logic              home_ok;
        logic [7:0]        step;
        logic [7:0]        limit;
        logic [8:0]        prog_base;
        logic [7:0]        done_base;
        logic [9:0]        prog_sum;
        logic [7:0]        done_inc;
        logic              hit;
        logic [1:0]        status;
        logic [8:0]        pan_diff;

        sum_w = {1'b0, item.light_nw} + {1'b0, item.light_sw};
        sum_e = {1'b0, item.light_ne} + {1'b0, item.light_se};
        sum_n = {1'b0, item.light_nw} + {1'b0, item.light_ne};
        sum_s = {1'b0, item.light_sw} + {1'b0, item.light_se};
        dh    = signed'({1'b0, sum_w[10:1]}) - signed'({1'b0, sum_e[10:1]});
        dv    = signed'({1'b0, sum_n[10:1]}) - signed'({1'b0, sum_s[10:1]});
        mag_h = dh[10] ? 11'(-dh) : 11'(dh);
        mag_v = dv[10] ? 11'(-dv) : 11'(dv);
        move_h = mag_h > {1'b0, cfg.track_threshold};
        move_v = mag_v > {1'b0, cfg.track_threshold};
        pan_up = (!dh[10] && dh != 11'sd0) == (st.tilt <= fst_pkg::TILT_MID);

        home_ok   = cfg.tilt_home <= TILT_TOP;
        step      = (cfg.search_step_deg == 8'd0) ? 8'd1 : cfg.search_step_deg;
        limit     = (cfg.search_sweeps == 8'd0) ? 8'd1 : cfg.search_sweeps;
        prog_base = st.searching ? st.sweep_progress : 9'd0;
        done_base = st.searching ? st.sweeps_done : 8'd0;
        prog_sum  = {1'b0, prog_base} + {2'b00, step};
        done_inc  = done_base + 8'd1;
        hit = (item.light_nw > cfg.search_tolerance) || (item.light_ne > cfg.search_tolerance)
           || (item.light_sw > cfg.search_tolerance) || (item.light_se > cfg.search_tolerance);

        st_next  = st;
        status   = fst_pkg::STAT_IDLE;
        pan_move = 1'b0;
        pan_tgt  = {1'b0, st.heading};
        tilt_a   = st.tilt;

        case (item.func)
            fst_pkg::FUNC_TRACK:
            begin
                st_next.searching = 1'b0;
                if (move_h)
                begin
                    pan_move = 1'b1;
                    if (pan_up)
                        pan_tgt = {1'b0, st.heading} + 10'd1;
                    else if (st.heading == 9'd0)
                        pan_tgt = PAN_MAX;
                    else
                        pan_tgt = {1'b0, st.heading} - 10'd1;
                end
            end
            fst_pkg::FUNC_SEARCH:
            begin
                if (!st.searching && home_ok)
                    tilt_a = cfg.tilt_home;
                st_next.sweep_progress = prog_base;
                st_next.sweeps_done    = done_base;
                if (hit)
                begin
                    st_next.searching = 1'b0;
                    status            = fst_pkg::STAT_FOUND;
                end
                else
                begin
                    pan_move          = 1'b1;
                    pan_tgt           = {1'b0, st.heading} + {2'b00, step};
                    st_next.searching = 1'b1;
                    status            = fst_pkg::STAT_SEARCHING;
                    if (prog_sum > PAN_MAX)
                    begin
                        st_next.sweep_progress = 9'd0;
                        st_next.sweeps_done    = done_inc;
                        if (done_inc >= limit)
                        begin
                            st_next.searching = 1'b0;
                            status            = fst_pkg::STAT_GIVE_UP;
                        end
                    end
                    else
                    begin
                        st_next.sweep_progress = prog_sum[8:0];
                    end
                end
            end
            fst_pkg::FUNC_EAST:
            begin
                st_next.searching = 1'b0;
                if (home_ok)
                    tilt_a = cfg.tilt_home;
                pan_move = 1'b1;
                pan_tgt  = {1'b0, st.heading} + fst_pkg::HALF_TURN;
            end
            default:
            begin
                st_next.searching = 1'b0;
            end
        endcase

        // crossing the flip heading mirrors the tilt
        pan_nxt = pan_wrap(pan_tgt);
        tilt_b  = tilt_a;
        if (pan_move)
        begin
            st_next.heading = pan_nxt;
            if ((st.heading > fst_pkg::PAN_FLIP) != (pan_nxt > fst_pkg::PAN_FLIP))
                tilt_b = TILT_TOP - tilt_a;
        end

        st_next.tilt = tilt_b;
        if (item.func == fst_pkg::FUNC_TRACK && move_v)
        begin
            if (!dv[10])
            begin
                if (tilt_b != 8'd0)
                    st_next.tilt = tilt_b - 8'd1;
            end
            else if (tilt_b < TILT_TOP)
            begin
                st_next.tilt = tilt_b + 8'd1;
            end
        end

        pan_diff = st_next.heading - fst_pkg::PAN_FLIP;
        if (st_next.heading > fst_pkg::PAN_FLIP)
            res.pan_servo = pan_diff[8] ? fst_pkg::SERVO_MAX : pan_diff[7:0];
        else
            res.pan_servo = st_next.heading[7:0];
        res.tilt_servo    = st_next.tilt;
        res.pan_heading   = st_next.heading;
        res.pane_flipped  = st_next.heading > fst_pkg::PAN_FLIP;
        res.search_status = status;
    end

endmodule

// File: design/four_sensor_solar_tracker.sv
// four_sensor_solar_tracker: top level, input register, step logic, state and result registers
// depends on fst_pkg, the three channel interfaces, fst_cfg_regs and fst_step

// Takes one item per cycle on sample while result is not stalled and gives one result per
// item on result. The item is captured in the input register at the accepting edge; once
// result is not stalled, the step logic, working from it and the current pan/tilt/search
// state, loads the result register and the state registers together, and the result is
// offered from the result register. Since the step logic is combinational and closes the
// state loop through the state registers, items can follow each other back to back; a
// stalled result holds the input register, and sample stays ready while that register is
// empty or moving on. The configuration port is always ready, one write per cycle; writes
// to indexes past the register list are ignored.

module four_sensor_solar_tracker #(
    parameter int unsigned PAN_RANGE  = 360,
    parameter int unsigned TILT_RANGE = 180
) (
    input  logic          clk,
    input  logic          rst_n,
    fst_sample_if.sink    sample,
    fst_result_if.source  result,
    fst_cfg_if.sink       cfg
);

    fst_pkg::cfg_t    regs;
    fst_pkg::sample_t s0_item_reg;
    logic             s0_valid_reg;
    fst_pkg::state_t  state_reg;
    fst_pkg::state_t  state_next;
    fst_pkg::result_t res_reg;
    fst_pkg::result_t res_next;
    logic             res_valid_reg;
    logic             advance;

    fst_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    fst_step #(
        .PAN_RANGE  (PAN_RANGE),
        .TILT_RANGE (TILT_RANGE)
    ) u_step (
        .item    (s0_item_reg),
        .st      (state_reg),
        .cfg     (regs),
        .st_next (state_next),
        .res     (res_next)
    );

    assign advance      = s0_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !s0_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg.heading        <= 9'd0;
            state_reg.tilt           <= fst_pkg::TILT_RESET;
            state_reg.searching      <= 1'b0;
            state_reg.sweep_progress <= 9'd0;
            state_reg.sweeps_done    <= 8'd0;
        end
        else
        begin
            if (sample.ready)
                s0_valid_reg <= sample.valid;
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s0_item_reg.func     <= sample.func;
            s0_item_reg.light_nw <= sample.light_nw;
            s0_item_reg.light_ne <= sample.light_ne;
            s0_item_reg.light_sw <= sample.light_sw;
            s0_item_reg.light_se <= sample.light_se;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign result.valid         = res_valid_reg;
    assign result.pan_servo     = res_reg.pan_servo;
    assign result.tilt_servo    = res_reg.tilt_servo;
    assign result.pan_heading   = res_reg.pan_heading;
    assign result.pane_flipped  = res_reg.pane_flipped;
    assign result.search_status = res_reg.search_status;

endmodule

// File: design/fst_checker.sv
// fst_checker: port-level checks on the tracker result channel, bound to the top level
// depends on four_sensor_solar_tracker and fst_pkg

module fst_checker #(
    parameter int unsigned PAN_RANGE  = 360,
    parameter int unsigned TILT_RANGE = 180
) (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [7:0] pan_servo,
    input logic [7:0] tilt_servo,
    input logic [8:0] pan_heading,
    input logic       pane_flipped,
    input logic [1:0] search_status
);

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(pan_servo) && $stable(tilt_servo)
            && $stable(pan_heading) && $stable(pane_flipped) && $stable(search_status))
        else $error("result beat changed while stalled");

    a_flip_flag: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> pane_flipped == (pan_heading > fst_pkg::PAN_FLIP))
        else $error("flip flag does not match heading");

    a_pan_servo: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !pane_flipped |-> pan_servo == pan_heading[7:0])
        else $error("pan servo does not follow unflipped heading");

    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> 32'(pan_heading) <= PAN_RANGE && 32'(tilt_servo) <= TILT_RANGE)
        else $error("angle out of range");

endmodule

bind four_sensor_solar_tracker fst_checker #(
    .PAN_RANGE  (PAN_RANGE),
    .TILT_RANGE (TILT_RANGE)
) u_fst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (result.valid),
    .ready         (result.ready),
    .pan_servo     (result.pan_servo),
    .tilt_servo    (result.tilt_servo),
    .pan_heading   (result.pan_heading),
    .pane_flipped  (result.pane_flipped),
    .search_status (result.search_status)
);

// File: tb/four_sensor_solar_tracker_tb.sv
// four_sensor_solar_tracker_tb: self-checking bench for the solar tracker, directed and random steps
// depends on fst_pkg, fst_sample_if, fst_result_if, fst_cfg_if and four_sensor_solar_tracker
`timescale 1ns / 1ps

module four_sensor_solar_tracker_tb;

    localparam int unsigned PAN_RANGE      = 360;
    localparam int unsigned TILT_RANGE     = 180;
    localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          MAX_REPORTS    = 200;

    logic clk;
    logic rst_n;

    fst_sample_if sample_ch ();
    fst_result_if result_ch ();
    fst_cfg_if    cfg_ch ();

    four_sensor_solar_tracker #(
        .PAN_RANGE  (PAN_RANGE),
        .TILT_RANGE (TILT_RANGE)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // tracker model: settings and pose
    int unsigned cfg_thr;
    int unsigned cfg_tol;
    int unsigned cfg_step;
    int unsigned cfg_sweeps;
    int unsigned cfg_home;
    int unsigned pose_heading;
    int unsigned pose_tilt;
    bit          seek_active;
    int unsigned seek_progress;
    int unsigned seek_sweeps_done;

    fst_pkg::result_t pose_queue[$];
    int      mismatch_count = 0;
    int      result_count = 0;
    int      src_idle_pct;
    int      snk_idle_pct;
    int      stall_cycles = 0;

    function automatic void aim_tilt(input int unsigned target);
        if (target <= TILT_RANGE)
            pose_tilt = target;
    endfunction

    function automatic void shift_heading(input int unsigned target);
        int unsigned nxt;
        nxt = target % (PAN_RANGE + 1);
        if ((pose_heading > fst_pkg::PAN_FLIP) != (nxt > fst_pkg::PAN_FLIP))
            aim_tilt(TILT_RANGE - pose_tilt);
        pose_heading = nxt;
    endfunction

    function automatic void heading_down();
        if (pose_heading == 0)
            shift_heading(PAN_RANGE);
        else
            shift_heading(pose_heading - 1);
    endfunction

    function automatic void reset_tracker_model();
        cfg_thr          = 50;
        cfg_tol          = 500;
        cfg_step         = 10;
        cfg_sweeps       = 2;
        cfg_home         = 45;
        pose_heading     = 0;
        pose_tilt        = fst_pkg::TILT_RESET;
        seek_active      = 1'b0;
        seek_progress    = 0;
        seek_sweeps_done = 0;
    endfunction

    function automatic fst_pkg::result_t step_tracker(input fst_pkg::sample_t s);
        fst_pkg::result_t r;
        int          nw, ne, sw, se, dh, dv, thr;
        int unsigned stride, sweep_limit, pan_out;
        logic [1:0]  status;
        nw = int'(s.light_nw);
        ne = int'(s.light_ne);
        sw = int'(s.light_sw);
        se = int'(s.light_se);
        status = fst_pkg::STAT_IDLE;
        case (s.func)
            fst_pkg::FUNC_TRACK:
            begin
                dh = (nw + sw) / 2 - (ne + se) / 2;
                dv = (nw + ne) / 2 - (sw + se) / 2;
                thr = int'(cfg_thr);
                seek_active = 1'b0;
                // pan decision uses the tilt from before this step
                if (dh > thr || dh < -thr)
                begin
                    if ((dh > 0) == (pose_tilt <= fst_pkg::TILT_MID))
                        shift_heading(pose_heading + 1);
                    else
                        heading_down();
                end
                if (dv > thr || dv < -thr)
                begin
                    if (dv > 0)
                    begin
                        if (pose_tilt > 0)
                            aim_tilt(pose_tilt - 1);
                    end
                    else if (pose_tilt < TILT_RANGE)
                        aim_tilt(pose_tilt + 1);
                end
            end
            fst_pkg::FUNC_SEARCH:
            begin
                if (!seek_active)
                begin
                    aim_tilt(cfg_home);
                    seek_active      = 1'b1;
                    seek_progress    = 0;
                    seek_sweeps_done = 0;
                end
                if (nw > int'(cfg_tol) || ne > int'(cfg_tol) ||
                    sw > int'(cfg_tol) || se > int'(cfg_tol))
                begin
                    seek_active = 1'b0;
                    status = fst_pkg::STAT_FOUND;
                end
                else
                begin
                    stride      = (cfg_step == 0) ? 1 : cfg_step;
                    sweep_limit = (cfg_sweeps == 0) ? 1 : cfg_sweeps;
                    shift_heading(pose_heading + stride);
                    seek_progress += stride;
                    status = fst_pkg::STAT_SEARCHING;
                    if (seek_progress > PAN_RANGE)
                    begin
                        seek_progress = 0;
                        seek_sweeps_done = (seek_sweeps_done + 1) & 8'hFF;
                        if (seek_sweeps_done >= sweep_limit)
                        begin
                            seek_active = 1'b0;
                            status = fst_pkg::STAT_GIVE_UP;
                        end
                    end
                end
            end
            fst_pkg::FUNC_EAST:
            begin
                seek_active = 1'b0;
                aim_tilt(cfg_home);
                shift_heading(pose_heading + fst_pkg::HALF_TURN);
            end
            default:
                seek_active = 1'b0;
        endcase
        if (pose_heading > fst_pkg::PAN_FLIP)
        begin
            pan_out = pose_heading - fst_pkg::PAN_FLIP;
            if (pan_out > fst_pkg::SERVO_MAX)
                pan_out = fst_pkg::SERVO_MAX;
        end
        else
            pan_out = pose_heading;
        r.pan_servo     = pan_out[7:0];
        r.tilt_servo    = pose_tilt[7:0];
        r.pan_heading   = pose_heading[8:0];
        r.pane_flipped  = (pose_heading > fst_pkg::PAN_FLIP);
        r.search_status = status;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch at result %0d, %s: got %0d, expected %0d",
                     result_count, what, got, want);
        mismatch_count++;
    endtask

    // one sample beat; the model steps at the edge that accepts it
    task automatic send_sample(input fst_pkg::sample_t s);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid    <= 1'b1;
        sample_ch.func     <= s.func;
        sample_ch.light_nw <= s.light_nw;
        sample_ch.light_ne <= s.light_ne;
        sample_ch.light_sw <= s.light_sw;
        sample_ch.light_se <= s.light_se;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        pose_queue.push_back(step_tracker(s));
    endtask

    task automatic send_lights(input logic [1:0] func, input int unsigned nw, ne, sw, se);
        fst_pkg::sample_t s;
        s.func     = func;
        s.light_nw = nw[9:0];
        s.light_ne = ne[9:0];
        s.light_sw = sw[9:0];
        s.light_se = se[9:0];
        send_sample(s);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (pose_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fst_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value[fst_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            fst_pkg::CFG_TRACK_THRESHOLD:  cfg_thr    = value & 10'h3FF;
            fst_pkg::CFG_SEARCH_TOLERANCE: cfg_tol    = value & 10'h3FF;
            fst_pkg::CFG_SEARCH_STEP_DEG:  cfg_step   = value & 8'hFF;
            fst_pkg::CFG_SEARCH_SWEEPS:    cfg_sweeps = value & 8'hFF;
            fst_pkg::CFG_TILT_HOME:        cfg_home   = value & 8'hFF;
            default: ;
        endcase
    endtask

    // settings change only with the tracker quiet
    task automatic load_config(input int unsigned thr, tol, step, sweeps, home);
        drain();
        write_reg(fst_pkg::CFG_TRACK_THRESHOLD, thr);
        write_reg(fst_pkg::CFG_SEARCH_TOLERANCE, tol);
        write_reg(fst_pkg::CFG_SEARCH_STEP_DEG, step);
        write_reg(fst_pkg::CFG_SEARCH_SWEEPS, sweeps);
        write_reg(fst_pkg::CFG_TILT_HOME, home);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [9:0] near_level(input int base, input int spread);
        int v;
        v = base + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v[9:0];
    endfunction

    function automatic fst_pkg::sample_t random_sample(input logic [1:0] func);
        fst_pkg::sample_t s;
        s.func     = func;
        s.light_nw = 10'($urandom_range(1023));
        s.light_ne = 10'($urandom_range(1023));
        s.light_sw = 10'($urandom_range(1023));
        s.light_se = 10'($urandom_range(1023));
        return s;
    endfunction

    // half the time levels cluster so the pair differences straddle the threshold
    function automatic fst_pkg::sample_t make_track_sample();
        fst_pkg::sample_t s;
        int      base, spread;
        s = random_sample(fst_pkg::FUNC_TRACK);
        if ($urandom_range(1))
        begin
            base       = int'($urandom_range(1023));
            spread     = 2 * int'(cfg_thr) + 8;
            s.light_nw = near_level(base, spread);
            s.light_ne = near_level(base, spread);
            s.light_sw = near_level(base, spread);
            s.light_se = near_level(base, spread);
        end
        return s;
    endfunction

    function automatic fst_pkg::sample_t make_search_sample(input bit bright);
        fst_pkg::sample_t s;
        s.func     = fst_pkg::FUNC_SEARCH;
        s.light_nw = 10'($urandom_range(cfg_tol));
        s.light_ne = 10'($urandom_range(cfg_tol));
        s.light_sw = 10'($urandom_range(cfg_tol));
        s.light_se = 10'($urandom_range(cfg_tol));
        if (bright && cfg_tol < 1023)
        begin
            case ($urandom_range(3))
                0: s.light_nw = 10'($urandom_range(1023, cfg_tol + 1));
                1: s.light_ne = 10'($urandom_range(1023, cfg_tol + 1));
                2: s.light_sw = 10'($urandom_range(1023, cfg_tol + 1));
                default: s.light_se = 10'($urandom_range(1023, cfg_tol + 1));
            endcase
        end
        return s;
    endfunction

    task automatic test_track_directed();
        send_lights(fst_pkg::FUNC_TRACK, 0, 0, 0, 0);
        send_lights(fst_pkg::FUNC_TRACK, 1023, 0, 1023, 0);
        send_lights(fst_pkg::FUNC_TRACK, 0, 1023, 0, 1023);
        // pan below zero wraps to the top and flips the pane
        send_lights(fst_pkg::FUNC_TRACK, 0, 1023, 0, 1023);
        send_lights(fst_pkg::FUNC_TRACK, 1023, 1023, 0, 0);
        send_lights(fst_pkg::FUNC_TRACK, 0, 0, 1023, 1023);
        send_lights(fst_pkg::FUNC_TRACK, 1023, 1023, 1023, 1023);
        send_lights(fst_pkg::FUNC_TRACK, 1023, 0, 0, 0);
        // difference equal to the threshold holds, one above moves
        send_lights(fst_pkg::FUNC_TRACK, 50, 0, 50, 0);
        send_lights(fst_pkg::FUNC_TRACK, 51, 0, 51, 0);
    endtask

    task automatic test_tilt_limits();
        load_config(50, 500, 10, 2, 0);
        send_lights(fst_pkg::FUNC_SEARCH, 1023, 0, 0, 0);
        send_lights(fst_pkg::FUNC_TRACK, 1023, 1023, 0, 0);
        load_config(50, 500, 10, 2, 180);
        send_lights(fst_pkg::FUNC_SEARCH, 0, 1023, 0, 0);
        send_lights(fst_pkg::FUNC_TRACK, 0, 0, 1023, 1023);
        // tilt home out of range leaves tilt alone
        load_config(50, 500, 10, 2, 255);
        send_lights(fst_pkg::FUNC_SEARCH, 0, 0, 0, 1023);
        send_lights(fst_pkg::FUNC_EAST, 0, 0, 0, 0);
    endtask

    task automatic test_search_directed();
        // zero sweeps count as one, so three half turns give up
        load_config(50, 500, 180, 0, 45);
        send_lights(fst_pkg::FUNC_SEARCH, 500, 500, 500, 500);
        send_lights(fst_pkg::FUNC_SEARCH, 0, 0, 0, 0);
        send_lights(fst_pkg::FUNC_SEARCH, 0, 0, 0, 0);
        send_lights(fst_pkg::FUNC_SEARCH, 0, 0, 501, 0);
        // zero step counts as one degree
        load_config(1023, 500, 0, 5, 90);
        send_lights(fst_pkg::FUNC_SEARCH, 0, 0, 0, 0);
        send_lights(fst_pkg::FUNC_TRACK, 1023, 0, 0, 0);
        send_lights(fst_pkg::FUNC_SEARCH, 200, 100, 0, 400);
        send_lights(FUNC_UNUSED, 1023, 1023, 1023, 1023);
    endtask

    task automatic test_turn_east();
        load_config(50, 500, 10, 2, 45);
        send_lights(fst_pkg::FUNC_EAST, 0, 0, 0, 0);
        send_lights(fst_pkg::FUNC_EAST, 1023, 1023, 1023, 1023);
        send_lights(fst_pkg::FUNC_EAST, 0, 0, 0, 0);
        send_lights(FUNC_UNUSED, 0, 0, 0, 0);
    endtask

    // bursts: track runs, search runs up to give-up length (at most 90), single east, odd codes
    task automatic test_random_traffic(input int n);
        int      sent, kind, run, need, k;
        bit      bright;
        fst_pkg::sample_t s;
        sent = 0;
        while (sent < n)
        begin
            kind = int'($urandom_range(99));
            if (kind < 40)
            begin
                run = int'($urandom_range(12, 1));
                for (k = 0; k < run && sent < n; k++)
                begin
                    send_sample(make_track_sample());
                    sent++;
                end
            end
            else if (kind < 75)
            begin
                need = (int'(PAN_RANGE + 1) / int'((cfg_step == 0) ? 1 : cfg_step) + 1)
                       * int'((cfg_sweeps == 0) ? 1 : cfg_sweeps) + 2;
                if (need > 90)
                    need = 90;
                run = int'($urandom_range(need, 1));
                for (k = 0; k < run && sent < n; k++)
                begin
                    bright = ($urandom_range(19) == 0) || (k == run - 1 && $urandom_range(1));
                    send_sample(make_search_sample(bright));
                    sent++;
                end
            end
            else if (kind < 88)
            begin
                send_sample(random_sample(fst_pkg::FUNC_EAST));
                sent++;
            end
            else
            begin
                s = random_sample(2'($urandom_range(3)));
                if (kind < 94)
                    s.func = FUNC_UNUSED;
                send_sample(s);
                sent++;
            end
        end
    endtask

    // result side: compare each beat, then pick next cycle's ready
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                if (pose_queue.size() == 0)
                    report_mismatch("unexpected result", int'(result_ch.pan_heading), 0);
                else
                begin
                    fst_pkg::result_t want;
                    want = pose_queue.pop_front();
                    if (result_ch.pan_servo !== want.pan_servo)
                        report_mismatch("pan_servo", int'(result_ch.pan_servo),
                                        int'(want.pan_servo));
                    if (result_ch.tilt_servo !== want.tilt_servo)
                        report_mismatch("tilt_servo", int'(result_ch.tilt_servo),
                                        int'(want.tilt_servo));
                    if (result_ch.pan_heading !== want.pan_heading)
                        report_mismatch("pan_heading", int'(result_ch.pan_heading),
                                        int'(want.pan_heading));
                    if (result_ch.pane_flipped !== want.pane_flipped)
                        report_mismatch("pane_flipped", int'(result_ch.pane_flipped),
                                        int'(want.pane_flipped));
                    if (result_ch.search_status !== want.search_status)
                        report_mismatch("search_status", int'(result_ch.search_status),
                                        int'(want.search_status));
                end
                result_count++;
            end
            result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        src_idle_pct   = 14;
        snk_idle_pct   = 72;
        reset_tracker_model();
        rst_n              <= 1'b0;
        sample_ch.valid    <= 1'b0;
        sample_ch.func     <= fst_pkg::FUNC_TRACK;
        sample_ch.light_nw <= '0;
        sample_ch.light_ne <= '0;
        sample_ch.light_sw <= '0;
        sample_ch.light_se <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= fst_pkg::CFG_TRACK_THRESHOLD;
        cfg_ch.data        <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_track_directed();
        test_tilt_limits();
        test_search_directed();
        test_turn_east();

        load_config(50, 500, 10, 2, 45);
        test_random_traffic(110);
        load_config(0, 1023, 180, 1, 180);
        test_random_traffic(110);

        drain();
        src_idle_pct = 72;
        snk_idle_pct = 14;
        load_config(1023, 0, 1, 255, 0);
        test_random_traffic(110);
        load_config($urandom_range(200), $urandom_range(900, 200), $urandom_range(180, 1),
                    $urandom_range(4, 1), $urandom_range(200));
        test_random_traffic(110);

        drain();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        load_config($urandom_range(1023), $urandom_range(1023), $urandom_range(180, 1),
                    $urandom_range(3, 1), $urandom_range(180));
        test_random_traffic(100);
        load_config(5, 700, 0, 0, 90);
        test_random_traffic(100);

        drain();
        if (mismatch_count == 0 && pose_queue.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
